FILE: hdl/utf8_name_validator_macros.svh
// Assertion macros for the UTF-8 name validator.
// Included by modules that carry concurrent checks; relies on clk and rst_n in scope.
`ifndef UTF8_NAME_VALIDATOR_MACROS_SVH
`define UTF8_NAME_VALIDATOR_MACROS_SVH
`ifndef SYNTH
`define UNV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define UNV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UNV_ASSERT_IMP(lbl, ante, cons, msg)
`define UNV_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/unv_pkg.sv
// Shared types and constants for the UTF-8 name validator.
// No dependencies; used by unv_step and utf8_name_validator.
package unv_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [6:0] MIN_POINTS_RST = 7'd2;
  localparam logic [6:0] MAX_POINTS_RST = 7'd16;
  localparam logic [6:0] POINT_SAT      = 7'd127;
  localparam logic [6:0] POINT_SHOW_MAX = 7'd64;

  localparam logic [7:0] ASCII_END  = 8'h80;
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [7:0] LEAD_SURR  = 8'hed;
  localparam logic [7:0] CONT_A0    = 8'ha0;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [20:0] CTRL_LO_END = 21'h20;
  localparam logic [20:0] CTRL_HI_LO  = 21'h7f;
  localparam logic [20:0] CTRL_HI_HI  = 21'h9f;

  localparam logic [2:0] FAIL_NONE     = 3'd0;
  localparam logic [2:0] FAIL_LONG     = 3'd1;
  localparam logic [2:0] FAIL_SPACE    = 3'd2;
  localparam logic [2:0] FAIL_ENCODING = 3'd3;
  localparam logic [2:0] FAIL_CONTROL  = 3'd4;
  localparam logic [2:0] FAIL_COUNT    = 3'd5;

  localparam logic [0:0] REG_MIN = 1'b0;
  localparam logic [0:0] REG_MAX = 1'b1;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_GE_A0,
    RULE_LT_A0,
    RULE_GE_90,
    RULE_LT_90
  } rule_t;

  typedef struct packed {
    logic [6:0]  point_total;
    logic [1:0]  pending;
    logic [20:0] acc;
    rule_t       rule;
    logic [2:0]  fail;
    logic        lead_space;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic       name_valid;
    logic [2:0] fail_reason;
    logic [6:0] code_point_total;
  } out_beat_t;

endpackage

FILE: hdl/unv_step.sv
// Per-byte decode and rule check: next string state and the end-of-string result.
// Pure combinational; depends on unv_pkg.
module unv_step #(
  parameter int NAME_CAPACITY = unv_pkg::CAPACITY_DEF,
  localparam int BT_W = $clog2(NAME_CAPACITY + 1)
) (
  input  unv_pkg::dec_state_t st,
  input  logic [BT_W-1:0]     byte_total,
  input  unv_pkg::in_beat_t   beat,
  input  logic [6:0]          min_points,
  input  logic [6:0]          max_points,
  output unv_pkg::dec_state_t st_nxt,
  output logic [BT_W-1:0]     byte_total_nxt,
  output unv_pkg::out_beat_t  result
);

  localparam logic [BT_W-1:0] CAP = BT_W'(NAME_CAPACITY);

  unv_pkg::dec_state_t dec;
  logic [7:0]  b;
  logic        rule_bad;
  logic        cont_bad;
  logic        done;
  logic [20:0] cp;
  logic [2:0]  reason;

  assign b = beat.data_byte;
  assign byte_total_nxt = (byte_total < CAP) ? byte_total + BT_W'(1) : byte_total;

  always_comb begin
    case (st.rule)
      unv_pkg::RULE_GE_A0: rule_bad = (b < unv_pkg::CONT_A0);
      unv_pkg::RULE_LT_A0: rule_bad = (b >= unv_pkg::CONT_A0);
      unv_pkg::RULE_GE_90: rule_bad = (b < unv_pkg::CONT_90);
      unv_pkg::RULE_LT_90: rule_bad = (b >= unv_pkg::CONT_90);
      default:             rule_bad = 1'b0;
    endcase
  end

  assign cont_bad = (b[7:6] != 2'b10) || rule_bad;

  always_comb begin
    dec  = st;
    done = 1'b0;
    cp   = '0;
    if (byte_total == '0 && b == unv_pkg::SPACE_CHAR) begin
      dec.lead_space = 1'b1;
    end
    if (st.fail == unv_pkg::FAIL_NONE) begin
      if (st.pending == 2'd0) begin
        dec.rule = unv_pkg::RULE_NONE;
        if (b < unv_pkg::ASCII_END) begin
          done = 1'b1;
          cp   = {13'b0, b};
        end else if (b >= unv_pkg::LEAD2_LO && b <= unv_pkg::LEAD2_HI) begin
          dec.pending = 2'd1;
          dec.acc     = {16'b0, b[4:0]};
        end else if (b >= unv_pkg::LEAD3_LO && b <= unv_pkg::LEAD3_HI) begin
          dec.pending = 2'd2;
          dec.acc     = {17'b0, b[3:0]};
          if (b == unv_pkg::LEAD3_LO) begin
            dec.rule = unv_pkg::RULE_GE_A0;
          end else if (b == unv_pkg::LEAD_SURR) begin
            dec.rule = unv_pkg::RULE_LT_A0;
          end
        end else if (b >= unv_pkg::LEAD4_LO && b <= unv_pkg::LEAD4_HI) begin
          dec.pending = 2'd3;
          dec.acc     = {18'b0, b[2:0]};
          if (b == unv_pkg::LEAD4_LO) begin
            dec.rule = unv_pkg::RULE_GE_90;
          end else if (b == unv_pkg::LEAD4_HI) begin
            dec.rule = unv_pkg::RULE_LT_90;
          end
        end else begin
          dec.fail = unv_pkg::FAIL_ENCODING;
        end
      end else if (cont_bad) begin
        dec.fail = unv_pkg::FAIL_ENCODING;
      end else begin
        dec.rule    = unv_pkg::RULE_NONE;
        dec.acc     = {st.acc[14:0], b[5:0]};
        dec.pending = st.pending - 2'd1;
        if (st.pending == 2'd1) begin
          done = 1'b1;
          cp   = {st.acc[14:0], b[5:0]};
        end
      end
    end
    if (done) begin
      if (cp < unv_pkg::CTRL_LO_END ||
          (cp >= unv_pkg::CTRL_HI_LO && cp <= unv_pkg::CTRL_HI_HI)) begin
        dec.fail = unv_pkg::FAIL_CONTROL;
      end else if (st.point_total != unv_pkg::POINT_SAT) begin
        dec.point_total = st.point_total + 7'd1;
      end
    end
  end

  always_comb begin
    if (byte_total_nxt >= CAP) begin
      reason = unv_pkg::FAIL_LONG;
    end else if (dec.lead_space || b == unv_pkg::SPACE_CHAR) begin
      reason = unv_pkg::FAIL_SPACE;
    end else if (dec.fail != unv_pkg::FAIL_NONE) begin
      reason = dec.fail;
    end else if (dec.pending != 2'd0) begin
      reason = unv_pkg::FAIL_ENCODING;
    end else if (dec.point_total < min_points || dec.point_total > max_points) begin
      reason = unv_pkg::FAIL_COUNT;
    end else begin
      reason = unv_pkg::FAIL_NONE;
    end
  end

  assign st_nxt = dec;

  assign result.name_valid       = (reason == unv_pkg::FAIL_NONE);
  assign result.fail_reason      = reason;
  assign result.code_point_total = (dec.point_total > unv_pkg::POINT_SHOW_MAX) ?
                                   unv_pkg::POINT_SHOW_MAX : dec.point_total;

endmodule

FILE: hdl/utf8_name_validator.sv
// UTF-8 name validator top level: string state, result register, APB registers.
// Depends on unv_pkg, unv_step and utf8_name_validator_macros.svh.
// The result is registered into out_beat in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; in_stall rises only while a result waits under out_stall.
// Reset (rst_n low, synchronous): string state cleared, output empty,
// min/max code point registers back to 2 and 16.
`include "utf8_name_validator_macros.svh"

module utf8_name_validator #(
  parameter int NAME_CAPACITY = unv_pkg::CAPACITY_DEF,
  localparam int BT_W = $clog2(NAME_CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  unv_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output unv_pkg::out_beat_t out_beat,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  unv_pkg::dec_state_t st_r, st_nxt;
  logic [BT_W-1:0]     byte_total_r, byte_total_nxt;
  unv_pkg::out_beat_t  out_beat_r, result;
  logic                out_valid_r;
  logic [6:0]          min_r, max_r;
  logic                in_acc;
  logic                cfg_wr;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  unv_step #(
    .NAME_CAPACITY(NAME_CAPACITY)
  ) u_step (
    .st             (st_r),
    .byte_total     (byte_total_r),
    .beat           (in_beat),
    .min_points     (min_r),
    .max_points     (max_r),
    .st_nxt         (st_nxt),
    .byte_total_nxt (byte_total_nxt),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      byte_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_beat.last_byte) begin
          st_r         <= '0;
          byte_total_r <= '0;
        end else begin
          st_r         <= st_nxt;
          byte_total_r <= byte_total_nxt;
        end
      end
      if (in_acc && in_beat.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_beat.last_byte) begin
      out_beat_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= unv_pkg::MIN_POINTS_RST;
      max_r <= unv_pkg::MAX_POINTS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        unv_pkg::REG_MIN: min_r <= pwdata[6:0];
        unv_pkg::REG_MAX: max_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      unv_pkg::REG_MIN: prdata = {25'b0, min_r};
      unv_pkg::REG_MAX: prdata = {25'b0, max_r};
      default:          prdata = '0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `UNV_ASSERT_NXT(a_last_gives_result, in_acc && in_beat.last_byte, out_valid_r,
                  "last byte accepted but no result registered")
  `UNV_ASSERT_NXT(a_last_clears_state, in_acc && in_beat.last_byte,
                  byte_total_r == '0 && st_r.pending == 2'd0,
                  "string state not cleared after last byte")
  `UNV_ASSERT_IMP(a_valid_matches_reason, out_valid_r,
                  out_beat_r.name_valid == (out_beat_r.fail_reason == unv_pkg::FAIL_NONE),
                  "name_valid disagrees with fail_reason")
  `UNV_ASSERT_IMP(a_count_shown_capped, out_valid_r,
                  out_beat_r.code_point_total <= unv_pkg::POINT_SHOW_MAX,
                  "code_point_total above display cap")
  `UNV_ASSERT_IMP(a_byte_total_bound, 1'b1, byte_total_r <= BT_W'(NAME_CAPACITY),
                  "byte count beyond capacity")

endmodule
